// File: design/rar_pkg.sv
// Shared constants and types for the rational arithmetic reduction block.
`timescale 1ns / 1ps
`default_nettype none

package rar_pkg;

    // Default operand width and fixed result field width
    localparam int OPERAND_WIDTH_DEF = 16;
    localparam int RES_W             = 33;

    // Operation codes
    typedef logic [1:0] kind_t;
    localparam kind_t KIND_ADD = 2'd0;
    localparam kind_t KIND_SUB = 2'd1;
    localparam kind_t KIND_MUL = 2'd2;
    localparam kind_t KIND_DIV = 2'd3;

    // Result field type
    typedef logic signed [RES_W-1:0] res_t;

endpackage

`default_nettype wire

// File: design/rar_if.sv
// Valid/ready channel interfaces for operand words and result words.
`timescale 1ns / 1ps
`default_nettype none

interface rar_op_if #(
    parameter int OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH_DEF
) ();
    import rar_pkg::*;

    logic                            valid;
    logic                            ready;
    kind_t                           kind;
    logic signed [OPERAND_WIDTH-1:0] a_num;
    logic signed [OPERAND_WIDTH-1:0] a_den;
    logic signed [OPERAND_WIDTH-1:0] b_num;
    logic signed [OPERAND_WIDTH-1:0] b_den;

    modport source (
        output valid, kind, a_num, a_den, b_num, b_den,
        input  ready
    );

    modport sink (
        input  valid, kind, a_num, a_den, b_num, b_den,
        output ready
    );
endinterface

interface rar_res_if ();
    import rar_pkg::*;

    logic valid;
    logic ready;
    res_t res_num;
    res_t res_den;
    logic bad_den;

    modport source (
        output valid, res_num, res_den, bad_den,
        input  ready
    );

    modport sink (
        input  valid, res_num, res_den, bad_den,
        output ready
    );
endinterface

`default_nettype wire

// File: design/rar_addsub.sv
// Shared add/subtract unit with borrow out, used by the add, GCD and divide steps.
`timescale 1ns / 1ps
`default_nettype none

module rar_addsub #(
    parameter int WIDTH = 2 * rar_pkg::OPERAND_WIDTH_DEF + 1
) (
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    input  logic             sub,
    output logic [WIDTH-1:0] sum,
    output logic             borrow
);
    logic [WIDTH:0]   full;
    logic [WIDTH-1:0] b_eff;

    // Invert b and add one for subtraction
    assign b_eff  = sub ? ~b : b;
    assign full   = {1'b0, a} + {1'b0, b_eff} + (WIDTH + 1)'(sub);
    assign sum    = full[WIDTH-1:0];

    // No carry out on a subtraction means a < b
    assign borrow = sub & ~full[WIDTH];

endmodule

`default_nettype wire

// File: design/rational_arith_reduce.sv
// Top level: fraction add/sub/mul/div with reduction to lowest terms.
//
//  channel   dir  handshake      word
//  operand   in   valid/ready    kind, a_num, a_den, b_num, b_den
//  result    out  valid/ready    res_num, res_den, bad_den
//
//  One word at a time. Three products on one multiplier, a signed-magnitude
//  add for ADD/SUB that retries reversed on a borrow, then a binary GCD on the
//  shared add/subtract unit after common factors of two are stripped, then two
//  restoring divisions of 2*OPERAND_WIDTH quotient bits each. Zero numerator
//  or zero denominator skips the GCD and division. The finished word sits in
//  an output register, so the next operand is taken while it waits; a stalled
//  result only holds the sequencer in its last step. Reset is asynchronous
//  and empties the block.
`timescale 1ns / 1ps
`default_nettype none

module rational_arith_reduce #(
    parameter int OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    rar_op_if.sink    operand,
    rar_res_if.source result
);
    import rar_pkg::*;

    localparam int OW = OPERAND_WIDTH;
    localparam int MW = 2 * OW;
    localparam int AW = MW + 1;
    localparam int CW = $clog2(MW);
    localparam int EW = (MW > RES_W) ? MW : RES_W;

    // Operand slots
    localparam int AN = 0;
    localparam int AD = 1;
    localparam int BN = 2;
    localparam int BD = 3;

    // Sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL   = 4'd1;
    localparam logic [3:0] S_ADD   = 4'd2;
    localparam logic [3:0] S_ADD2  = 4'd3;
    localparam logic [3:0] S_CHECK = 4'd4;
    localparam logic [3:0] S_TWOS  = 4'd5;
    localparam logic [3:0] S_GCD   = 4'd6;
    localparam logic [3:0] S_DIVN  = 4'd7;
    localparam logic [3:0] S_DIVD  = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;

    // Two's complement of a magnitude, cut to the result width
    function automatic logic [RES_W-1:0] encode(input logic neg, input logic [MW-1:0] mag);
        logic [EW-1:0] ext;
        ext = EW'(mag);
        if (neg)
        begin
            ext = ~ext + EW'(1);
        end
        return ext[RES_W-1:0];
    endfunction

    // Control registers
    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          out_valid_reg, out_valid_next;

    // Datapath registers
    kind_t              kind_reg, kind_next;
    logic [3:0][OW-1:0] mag_reg, mag_next;
    logic [3:0]         neg_reg, neg_next;
    logic [MW-1:0]      num_reg, num_next;
    logic               num_neg_reg, num_neg_next;
    logic [MW-1:0]      t_reg, t_next;
    logic               t_neg_reg, t_neg_next;
    logic [MW-1:0]      den_reg, den_next;
    logic               den_neg_reg, den_neg_next;
    logic               bad_reg, bad_next;
    logic [MW-1:0]      x_reg, x_next;
    logic [MW-1:0]      y_reg, y_next;
    logic [CW-1:0]      k_reg, k_next;
    logic [MW-1:0]      g_reg, g_next;
    logic [MW-1:0]      dq_reg, dq_next;
    logic [MW-1:0]      rem_reg, rem_next;
    res_t               res_num_reg, res_num_next;
    res_t               res_den_reg, res_den_next;
    logic               res_bad_reg, res_bad_next;

    // Input magnitudes and signs
    logic [3:0][OW-1:0] raw_in;
    logic [3:0][OW-1:0] mag_in;
    logic [3:0]         neg_in;

    // Shared multiplier
    logic [1:0]    mx_sel, my_sel;
    logic [MW-1:0] prod;
    logic          prod_neg;

    // Shared add/subtract unit
    logic [AW-1:0] au_a, au_b, au_sum;
    logic          au_sub, au_borrow;

    // Divider step
    logic [MW-1:0] quo_shift;

    logic accept, out_take;

    assign accept   = operand.valid & operand.ready;
    assign out_take = out_valid_reg & result.ready;

    assign operand.ready  = (state_reg == S_IDLE);
    assign result.valid   = out_valid_reg;
    assign result.res_num = res_num_reg;
    assign result.res_den = res_den_reg;
    assign result.bad_den = res_bad_reg;

    // Split incoming operands into sign and magnitude
    assign raw_in[AN] = operand.a_num;
    assign raw_in[AD] = operand.a_den;
    assign raw_in[BN] = operand.b_num;
    assign raw_in[BD] = operand.b_den;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            neg_in[i] = raw_in[i][OW-1];
            mag_in[i] = raw_in[i][OW-1] ? (~raw_in[i] + OW'(1)) : raw_in[i];
        end
    end

    // Pick multiplier operands for the current product
    always_comb
    begin
        mx_sel = 2'(AN);
        my_sel = 2'(BD);
        if (cnt_reg == CW'(0))
        begin
            mx_sel = 2'(AN);
            my_sel = (kind_reg == KIND_MUL) ? 2'(BN) : 2'(BD);
        end
        else if (cnt_reg == CW'(1))
        begin
            mx_sel = 2'(AD);
            my_sel = 2'(BN);
        end
        else
        begin
            mx_sel = 2'(AD);
            my_sel = (kind_reg == KIND_DIV) ? 2'(BN) : 2'(BD);
        end
    end

    assign prod     = MW'(mag_reg[mx_sel]) * MW'(mag_reg[my_sel]);
    assign prod_neg = neg_reg[mx_sel] ^ neg_reg[my_sel];

    // Route operands to the shared add/subtract unit
    always_comb
    begin
        au_a   = '0;
        au_b   = '0;
        au_sub = 1'b0;
        unique case (state_reg) inside
            S_ADD:
            begin
                au_a   = AW'(num_reg);
                au_b   = AW'(t_reg);
                au_sub = (num_neg_reg != t_neg_reg);
            end
            S_ADD2:
            begin
                au_a   = AW'(t_reg);
                au_b   = AW'(num_reg);
                au_sub = 1'b1;
            end
            S_GCD:
            begin
                au_a   = AW'(x_reg);
                au_b   = AW'(y_reg);
                au_sub = 1'b1;
            end
            S_DIVN, S_DIVD:
            begin
                au_a   = {rem_reg, dq_reg[MW-1]};
                au_b   = AW'(g_reg);
                au_sub = 1'b1;
            end
            default:
            begin
                au_a   = '0;
                au_b   = '0;
                au_sub = 1'b0;
            end
        endcase
    end

    rar_addsub #(
        .WIDTH (AW)
    ) u_addsub (
        .a      (au_a),
        .b      (au_b),
        .sub    (au_sub),
        .sum    (au_sum),
        .borrow (au_borrow)
    );

    assign quo_shift = {dq_reg[MW-2:0], ~au_borrow};

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg & ~out_take;
        kind_next      = kind_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        num_next       = num_reg;
        num_neg_next   = num_neg_reg;
        t_next         = t_reg;
        t_neg_next     = t_neg_reg;
        den_next       = den_reg;
        den_neg_next   = den_neg_reg;
        bad_next       = bad_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        k_next         = k_reg;
        g_next         = g_reg;
        dq_next        = dq_reg;
        rem_next       = rem_reg;
        res_num_next   = res_num_reg;
        res_den_next   = res_den_reg;
        res_bad_next   = res_bad_reg;

        unique case (state_reg) inside
            S_IDLE:
            begin
                // Capture the operand word
                if (accept)
                begin
                    kind_next  = operand.kind;
                    mag_next   = mag_in;
                    neg_next   = neg_in;
                    cnt_next   = '0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                // Three products on one multiplier
                if (cnt_reg == CW'(0))
                begin
                    num_next     = prod;
                    num_neg_next = prod_neg;
                    cnt_next     = CW'(1);
                end
                else if (cnt_reg == CW'(1))
                begin
                    t_next     = prod;
                    t_neg_next = prod_neg ^ (kind_reg == KIND_SUB);
                    cnt_next   = CW'(2);
                end
                else
                begin
                    den_next     = prod;
                    den_neg_next = prod_neg;
                    cnt_next     = '0;
                    if (kind_reg == KIND_ADD || kind_reg == KIND_SUB)
                    begin
                        state_next = S_ADD;
                    end
                    else
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_ADD:
            begin
                // Signed-magnitude add; retry reversed when the difference borrows
                if (au_borrow)
                begin
                    state_next = S_ADD2;
                end
                else
                begin
                    num_next   = au_sum[MW-1:0];
                    state_next = S_CHECK;
                end
            end
            S_ADD2:
            begin
                num_next     = au_sum[MW-1:0];
                num_neg_next = t_neg_reg;
                state_next   = S_CHECK;
            end
            S_CHECK:
            begin
                // Zero denominator flags an error, zero numerator gives 0/1
                if (den_reg == '0)
                begin
                    num_next     = '0;
                    num_neg_next = 1'b0;
                    den_neg_next = 1'b0;
                    bad_next     = 1'b1;
                    state_next   = S_FIN;
                end
                else if (num_reg == '0)
                begin
                    num_neg_next = 1'b0;
                    den_next     = MW'(1);
                    den_neg_next = 1'b0;
                    bad_next     = 1'b0;
                    state_next   = S_FIN;
                end
                else
                begin
                    x_next     = num_reg;
                    y_next     = den_reg;
                    k_next     = '0;
                    bad_next   = 1'b0;
                    state_next = S_TWOS;
                end
            end
            S_TWOS:
            begin
                // Strip common factors of two
                if (!x_reg[0] && !y_reg[0])
                begin
                    x_next = x_reg >> 1;
                    y_next = y_reg >> 1;
                    k_next = k_reg + CW'(1);
                end
                else
                begin
                    state_next = S_GCD;
                end
            end
            S_GCD:
            begin
                // Binary GCD: halve evens, swap so x is the larger odd, subtract y from x
                if (x_reg == '0)
                begin
                    g_next     = y_reg << k_reg;
                    dq_next    = num_reg;
                    rem_next   = '0;
                    cnt_next   = CW'(MW - 1);
                    state_next = S_DIVN;
                end
                else if (!x_reg[0])
                begin
                    x_next = x_reg >> 1;
                end
                else if (!y_reg[0])
                begin
                    y_next = y_reg >> 1;
                end
                else if (au_borrow)
                begin
                    x_next = y_reg;
                    y_next = x_reg;
                end
                else
                begin
                    x_next = au_sum[MW-1:0];
                end
            end
            S_DIVN, S_DIVD:
            begin
                // One quotient bit per cycle
                rem_next = au_borrow ? au_a[MW-1:0] : au_sum[MW-1:0];
                dq_next  = quo_shift;
                if (cnt_reg == '0)
                begin
                    if (state_reg == S_DIVN)
                    begin
                        num_next   = quo_shift;
                        dq_next    = den_reg;
                        rem_next   = '0;
                        cnt_next   = CW'(MW - 1);
                        state_next = S_DIVD;
                    end
                    else
                    begin
                        den_next   = quo_shift;
                        state_next = S_FIN;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            S_FIN:
            begin
                // Hand the word to the output register once it is free
                if (!out_valid_reg || result.ready)
                begin
                    res_num_next   = encode(num_neg_reg, num_reg);
                    res_den_next   = encode(den_neg_reg, den_reg);
                    res_bad_next   = bad_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath state
    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        mag_reg     <= mag_next;
        neg_reg     <= neg_next;
        num_reg     <= num_next;
        num_neg_reg <= num_neg_next;
        t_reg       <= t_next;
        t_neg_reg   <= t_neg_next;
        den_reg     <= den_next;
        den_neg_reg <= den_neg_next;
        bad_reg     <= bad_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        k_reg       <= k_next;
        g_reg       <= g_next;
        dq_reg      <= dq_next;
        rem_reg     <= rem_next;
        res_num_reg <= res_num_next;
        res_den_reg <= res_den_next;
        res_bad_reg <= res_bad_next;
    end

endmodule

`default_nettype wire
